// File: design/csx_pkg.sv
// Shared types, constants and the quarter-round function for the ChaCha20 stream XOR block.
// No dependencies.
package csx_pkg;

  localparam int DOUBLE_ROUNDS_DEF = 10;
  localparam int QUEUE_DEPTH_DEF   = 2;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 64;

  localparam logic [CFG_IDX_W-1:0] REG_KEY0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_L = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_H = 3'd5;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  typedef logic [15:0][31:0] word16_t;
  typedef logic [3:0][31:0]  quad_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] result_byte;
    logic       result_last;
  } out_item_t;

  typedef struct packed {
    logic [7:0][31:0] key;
    logic [31:0]      counter;
    logic [2:0][31:0] nonce;
  } blk_in_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

  function automatic quad_t quarter(input quad_t q);
    logic [31:0] a, b, c, d;
    a = q[0]; b = q[1]; c = q[2]; d = q[3];
    a = a + b; d = rotl(d ^ a, 16);
    c = c + d; b = rotl(b ^ c, 12);
    a = a + b; d = rotl(d ^ a, 8);
    c = c + d; b = rotl(b ^ c, 7);
    quarter = {d, c, b, a};
  endfunction

endpackage

// File: design/chacha20_stream_xor.sv
// ChaCha20 stream XOR (256-bit key, 96-bit nonce), top level.
// Channels: in_push/in_full take one byte beat with a last flag; out_empty/out_pop
// deliver one result beat per input beat, in order. cfg_we/cfg_idx/cfg_wdata write
// key_part0..3 (0..3), nonce_low (4), nonce_high (5); other indexes are dropped.
// Bytes enter a small queue and are handled one per cycle by the back end, unless it
// waits for a keystream block or the result queue is full. The first byte of each
// 64-byte block starts the block function (2*DOUBLE_ROUNDS rounds); that byte is
// handled once the keystream block is ready. Other bytes pass through the input
// queue and the result queue to the result ports. The block function runs one
// round per cycle.
// After a last byte the counter returns to 1 and the position to 0.
// Reset (rst_n low, synchronous) empties both queues, clears key and nonce, sets
// the counter to 1. When the receiver stops popping, the result queue fills, the
// back end holds and in_full rises once the input queue is full.
// Depends on csx_pkg, csx_fifo, csx_core.
module chacha20_stream_xor #(
  parameter int DOUBLE_ROUNDS = csx_pkg::DOUBLE_ROUNDS_DEF,
  parameter int QUEUE_DEPTH   = csx_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  input  csx_pkg::in_item_t                    in_item,
  output logic                                 in_full,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output csx_pkg::out_item_t                   out_item,
  input  logic                                 cfg_we,
  input  logic [csx_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  logic [csx_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import csx_pkg::*;

  typedef enum logic [1:0] {
    S_RUN = 2'b01,
    S_GEN = 2'b10
  } state_t;

  state_t      state_r, state_nxt;
  logic [63:0] key_r [4];
  logic [63:0] nonce_lo_r;
  logic [31:0] nonce_hi_r;
  logic [31:0] count_r, count_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic        ks_ok_r, ks_ok_nxt;
  word16_t     ks_words_r;

  in_item_t    head;
  out_item_t   res;
  logic        q_empty, q_pop, o_full, o_push;
  logic        start, core_done;
  blk_in_t     blk;
  word16_t     core_ks;
  logic [31:0] ks_word;
  logic [7:0]  ks_byte;

  csx_fifo #(.W($bits(in_item_t)), .DEPTH(QUEUE_DEPTH)) u_in_q (
    .clk(clk), .rst_n(rst_n),
    .push(in_push), .wdata(in_item), .full(in_full),
    .pop(q_pop), .rdata(head), .empty(q_empty)
  );

  csx_fifo #(.W($bits(out_item_t)), .DEPTH(QUEUE_DEPTH)) u_out_q (
    .clk(clk), .rst_n(rst_n),
    .push(o_push), .wdata(res), .full(o_full),
    .pop(out_pop), .rdata(out_item), .empty(out_empty)
  );

  always_comb begin
    blk.key     = {key_r[3], key_r[2], key_r[1], key_r[0]};
    blk.counter = count_r;
    blk.nonce   = {nonce_hi_r, nonce_lo_r};
  end

  csx_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core (
    .clk(clk), .rst_n(rst_n), .start(start), .blk(blk),
    .done(core_done), .ks(core_ks)
  );

  assign ks_word = ks_words_r[pos_r[5:2]];
  assign ks_byte = ks_word[{pos_r[1:0], 3'b000} +: 8];

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    ks_ok_nxt = ks_ok_r;
    start     = 1'b0;
    q_pop     = 1'b0;
    o_push    = 1'b0;
    res.result_byte = head.data_byte ^ ks_byte;
    res.result_last = head.last_byte;
    case (state_r)
      S_RUN: begin
        if (!q_empty && !o_full) begin
          if (pos_r == '0 && !ks_ok_r) begin
            start     = 1'b1;
            state_nxt = S_GEN;
          end else begin
            q_pop  = 1'b1;
            o_push = 1'b1;
            if (head.last_byte) begin
              count_nxt = 32'd1;
              pos_nxt   = '0;
              ks_ok_nxt = 1'b0;
            end else begin
              pos_nxt = pos_r + 1'b1;
              if (pos_r == 6'h3f) begin
                count_nxt = count_r + 1'b1;
                ks_ok_nxt = 1'b0;
              end
            end
          end
        end
      end
      S_GEN: begin
        if (core_done) begin
          ks_ok_nxt = 1'b1;
          state_nxt = S_RUN;
        end
      end
      default: state_nxt = S_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (core_done) begin
      ks_words_r <= core_ks;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_RUN;
      count_r    <= 32'd1;
      pos_r      <= '0;
      ks_ok_r    <= 1'b0;
      key_r[0]   <= '0;
      key_r[1]   <= '0;
      key_r[2]   <= '0;
      key_r[3]   <= '0;
      nonce_lo_r <= '0;
      nonce_hi_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pos_r   <= pos_nxt;
      ks_ok_r <= ks_ok_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          REG_KEY0:    key_r[0]   <= cfg_wdata;
          REG_KEY1:    key_r[1]   <= cfg_wdata;
          REG_KEY2:    key_r[2]   <= cfg_wdata;
          REG_KEY3:    key_r[3]   <= cfg_wdata;
          REG_NONCE_L: nonce_lo_r <= cfg_wdata;
          REG_NONCE_H: nonce_hi_r <= cfg_wdata[31:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// File: design/csx_fifo.sv
// Small register queue used between the front, the back and the result port.
// Depends on nothing but its parameters.
module csx_fifo #(
  parameter int W     = 9,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end
endmodule

// File: design/csx_core.sv
// ChaCha20 block function: one column or diagonal round per cycle, then the feed-forward add.
// Depends on csx_pkg.
module csx_core #(
  parameter int DOUBLE_ROUNDS = csx_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  csx_pkg::blk_in_t  blk,
  output logic              done,
  output csx_pkg::word16_t  ks
);
  import csx_pkg::*;

  localparam int NR = 2 * DOUBLE_ROUNDS;
  localparam int CW = $clog2(NR + 1);

  word16_t       init_r, work_r, init_nxt, rnd;
  logic [CW-1:0] cnt_r;
  logic          busy_r, fin_r;

  always_comb begin
    init_nxt = {blk.nonce[2], blk.nonce[1], blk.nonce[0], blk.counter,
                blk.key[7], blk.key[6], blk.key[5], blk.key[4],
                blk.key[3], blk.key[2], blk.key[1], blk.key[0],
                SIGMA3, SIGMA2, SIGMA1, SIGMA0};
  end

  always_comb begin
    quad_t q;
    rnd = work_r;
    for (int i = 0; i < 4; i++) begin
      if (!cnt_r[0]) begin
        q = quarter({work_r[12+i], work_r[8+i], work_r[4+i], work_r[i]});
        rnd[i] = q[0]; rnd[4+i] = q[1]; rnd[8+i] = q[2]; rnd[12+i] = q[3];
      end else begin
        q = quarter({work_r[12+((i+3)&3)], work_r[8+((i+2)&3)],
                     work_r[4+((i+1)&3)], work_r[i]});
        rnd[i] = q[0]; rnd[4+((i+1)&3)] = q[1];
        rnd[8+((i+2)&3)] = q[2]; rnd[12+((i+3)&3)] = q[3];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      ks[i] = work_r[i] + init_r[i];
    end
  end

  assign done = fin_r;

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      init_r <= init_nxt;
      work_r <= init_nxt;
    end else if (busy_r) begin
      work_r <= rnd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      fin_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NR - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end
endmodule

// File: bench/testbench.sv
// Self-checking bench for chacha20_stream_xor: keyed byte streams in, XORed beats checked out.
// Carries its own ChaCha20 keystream predictor; depends on csx_pkg and the block's RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import csx_pkg::*;

  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  in_item_t in_item = '0;
  logic in_full;
  logic out_empty;
  logic out_pop = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  chacha20_stream_xor u_top (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_item(in_item), .in_full(in_full),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [63:0] key_reg [4];
  logic [63:0] nonce_lo_reg;
  logic [31:0] nonce_hi_reg;
  logic [31:0] blk_ctr;
  logic [5:0]  byte_pos;
  logic [31:0] ks_word [16];
  logic [31:0] mix_w [16];
  out_item_t   xor_expected [$];
  int          errors = 0;
  int          beats_sent = 0;
  int          beats_checked = 0;
  int          msgs_sent = 0;
  int          cycles = 0;
  bit          steady = 1'b0;

  function automatic logic [31:0] rol32(logic [31:0] v, int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic void mix(int a, int b, int c, int d);
    mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rol32(mix_w[d] ^ mix_w[a], 16);
    mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rol32(mix_w[b] ^ mix_w[c], 12);
    mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rol32(mix_w[d] ^ mix_w[a], 8);
    mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rol32(mix_w[b] ^ mix_w[c], 7);
  endfunction

  function automatic void gen_keystream();
    logic [31:0] init [16];
    init[0] = SIGMA0; init[1] = SIGMA1; init[2] = SIGMA2; init[3] = SIGMA3;
    for (int i = 0; i < 8; i++)
      init[4+i] = key_reg[i/2][32*(i%2) +: 32];
    init[12] = blk_ctr;
    init[13] = nonce_lo_reg[31:0];
    init[14] = nonce_lo_reg[63:32];
    init[15] = nonce_hi_reg;
    for (int i = 0; i < 16; i++) mix_w[i] = init[i];
    for (int r = 0; r < DOUBLE_ROUNDS_DEF; r++) begin
      mix(0, 4, 8, 12); mix(1, 5, 9, 13); mix(2, 6, 10, 14); mix(3, 7, 11, 15);
      mix(0, 5, 10, 15); mix(1, 6, 11, 12); mix(2, 7, 8, 13); mix(3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) ks_word[i] = mix_w[i] + init[i];
  endfunction

  function automatic out_item_t predict_xor(in_item_t it);
    out_item_t r;
    if (byte_pos == 6'd0) gen_keystream();
    r.result_byte = it.data_byte ^ ks_word[byte_pos[5:2]][8*byte_pos[1:0] +: 8];
    r.result_last = it.last_byte;
    if (it.last_byte) begin
      blk_ctr = 32'd1;
      byte_pos = 6'd0;
    end else begin
      byte_pos = byte_pos + 6'd1;
      if (byte_pos == 6'd0) blk_ctr = blk_ctr + 32'd1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("%0t timeout with %0d beats outstanding", $time, xor_expected.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (xor_expected.size() == 0) begin
        $display("%0t unexpected beat: actual %h/%b", $time,
                 out_item.result_byte, out_item.result_last);
        errors++;
      end else begin
        out_item_t e;
        e = xor_expected.pop_front();
        if (out_item.result_byte !== e.result_byte) begin
          $display("%0t result_byte mismatch: expected %h actual %h", $time,
                   e.result_byte, out_item.result_byte);
          errors++;
        end
        if (out_item.result_last !== e.result_last) begin
          $display("%0t result_last mismatch: expected %b actual %b", $time,
                   e.result_last, out_item.result_last);
          errors++;
        end
        beats_checked++;
      end
    end
    out_pop <= steady ? 1'b1 : ($urandom_range(99) >= 34);
  end

  task automatic send_byte(logic [7:0] d, logic l);
    in_item_t it;
    it.data_byte = d;
    it.last_byte = l;
    in_push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_full);
    xor_expected.push_back(predict_xor(it));
    beats_sent++;
    if (l) msgs_sent++;
    if (!steady && $urandom_range(99) < 34) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic finish_send();
    in_push <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    finish_send();
    while (xor_expected.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_KEY0:    key_reg[0] = v;
      REG_KEY1:    key_reg[1] = v;
      REG_KEY2:    key_reg[2] = v;
      REG_KEY3:    key_reg[3] = v;
      REG_NONCE_L: nonce_lo_reg = v;
      REG_NONCE_H: nonce_hi_reg = v[31:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_all(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                          logic [63:0] k3, logic [63:0] nl, logic [63:0] nh);
    write_reg(REG_KEY0, k0); write_reg(REG_KEY1, k1);
    write_reg(REG_KEY2, k2); write_reg(REG_KEY3, k3);
    write_reg(REG_NONCE_L, nl); write_reg(REG_NONCE_H, nh);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_msg(int len);
    for (int i = 0; i < len; i++)
      send_byte(8'($urandom_range(255)), i == len - 1);
  endtask

  task automatic test_directed();
    send_byte(8'h00, 1'b0); send_byte(8'hff, 1'b0); send_byte(8'h5a, 1'b1);
    send_byte(8'hff, 1'b1);
    drain();
    load_all(64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 64'h1716151413121110,
             64'h1f1e1d1c1b1a1918, 64'h4a00000009000000, 64'hffffffff00000000);
    send_byte(8'h00, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h01, 1'b1);
    for (int i = 0; i < 66; i++) send_byte(i[7:0], i == 65);
    drain();
  endtask

  task automatic test_midblock_rekey();
    for (int i = 0; i < 10; i++) send_byte(8'($urandom_range(255)), 1'b0);
    drain();
    write_reg(REG_KEY2, rand64());
    write_reg(REG_NONCE_H, rand64());
    for (int i = 0; i < 60; i++) send_byte(8'($urandom_range(255)), i == 59);
    drain();
  endtask

  task automatic test_bad_index();
    write_reg(3'd6, rand64());
    write_reg(3'd7, '1);
    send_msg(5);
    drain();
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: load_all('1, '1, '1, '1, '1, '1);
        1: load_all('0, '0, '0, '0, '0, '0);
        default: load_all(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
      endcase
      steady = (phase == 3);
      for (int n = 0; n < 100; ) begin
        int len;
        len = ($urandom_range(9) == 0) ? $urandom_range(65, 140) : $urandom_range(1, 40);
        send_msg(len);
        n += len;
      end
      for (int i = 0; i < $urandom_range(1, 30); i++)
        send_byte(8'($urandom_range(255)), 1'b0);
      drain();
      steady = 1'b0;
    end
  endtask

  initial begin
    for (int i = 0; i < 4; i++) key_reg[i] = '0;
    nonce_lo_reg = '0;
    nonce_hi_reg = '0;
    blk_ctr = 32'd1;
    byte_pos = 6'd0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);
    test_directed();
    test_midblock_rekey();
    test_bad_index();
    test_random();
    $display("Covered %0d byte beats in %0d messages, %0d results checked,", beats_sent,
             msgs_sent, beats_checked);
    $display("across block boundaries, rekeys between bursts and ignored register writes.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
